// File: hw/rtl/phlm_pkg.sv
// ----------------------------------------------------------------------------
// phlm_pkg
// Shared types and constants for the peak-hold level meter.
// ----------------------------------------------------------------------------
package phlm_pkg;

  // field widths
  localparam int GAIN_W  = 16;
  localparam int NCH_W   = 2;
  localparam int TIME_W  = 32;
  localparam int HOLD_W  = 16;
  localparam int CLS_W   = 2;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;

  // stream widths, padded to whole bytes
  localparam int IN_RAW_W  = 2 * GAIN_W + NCH_W + TIME_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 4 * GAIN_W + 1 + CLS_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // reciprocal multipliers: floor(x/10) for x < 2^22, floor(y/5) for y < 2^19
  localparam int SUM_W      = GAIN_W + 4;
  localparam int DIV10_SH   = 23;
  localparam logic [SUM_W-1:0] DIV10_MULT = 20'd838861;
  localparam int DEC_W      = GAIN_W + 2;
  localparam int DIV5_SH    = 21;
  localparam logic [DEC_W:0] DIV5_MULT = 19'd419431;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_HOLD_TIME = 2'd0,
    REG_HOLD_EN   = 2'd1,
    REG_CLIP_THR  = 2'd2,
    REG_WARN_THR  = 2'd3
  } cfg_reg_t;

  // configuration reset values
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 16'd3000;
  localparam logic [GAIN_W-1:0] CLIP_THR_RST  = 16'd32768;
  localparam logic [GAIN_W-1:0] WARN_THR_RST  = 16'd8231;

  // level classes
  localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WARN = 2'd1;
  localparam logic [CLS_W-1:0] CLS_CLIP = 2'd2;

  // per-channel update result
  typedef struct packed {
    logic [GAIN_W-1:0] level;
    logic [GAIN_W-1:0] peak;
    logic [TIME_W-1:0] stamp;
    logic              changed;
    logic              decayed;
  } chan_res_t;

endpackage

// File: hw/rtl/phlm_chan.sv
// ----------------------------------------------------------------------------
// phlm_chan
// One channel's refresh: level smoothing, peak tracking, hold and decay.
// ----------------------------------------------------------------------------
module phlm_chan
  import phlm_pkg::*;
(
  input  logic [GAIN_W-1:0] gain,
  input  logic [GAIN_W-1:0] level,
  input  logic [GAIN_W-1:0] peak,
  input  logic [TIME_W-1:0] stamp,
  input  logic [TIME_W-1:0] now,
  input  logic              hold_en,
  input  logic [HOLD_W-1:0] hold_time,
  input  logic              upd,
  output chan_res_t         res
);

  logic [SUM_W-1:0]         sum;
  logic [2*SUM_W-1:0]       lv_prod;
  logic [GAIN_W-1:0]        lv;
  logic [DEC_W-1:0]         pk4;
  logic [2*DEC_W:0]         dec_prod;
  logic [GAIN_W-1:0]        pk_dec;
  logic [TIME_W-1:0]        elapsed;
  logic                     hold_over;

  // level + 9 * gain, then divide by ten
  assign sum     = SUM_W'(level) + (SUM_W'(gain) << 3) + SUM_W'(gain);
  assign lv_prod = sum * DIV10_MULT;
  assign lv      = lv_prod[DIV10_SH +: GAIN_W];

  // decayed peak: peak * 4 / 5
  assign pk4      = {peak, 2'b00};
  assign dec_prod = pk4 * DIV5_MULT;
  assign pk_dec   = dec_prod[DIV5_SH +: GAIN_W];

  // wrapping age of the held peak
  assign elapsed   = now - stamp;
  assign hold_over = elapsed > TIME_W'(hold_time);

  always_comb begin
    res = '{level: level, peak: peak, stamp: stamp, changed: 1'b0, decayed: 1'b0};
    if (upd) begin
      res.level = lv;
      if (hold_en) begin
        if (lv > peak) begin
          res.peak  = lv;
          res.stamp = now;
        end else if (hold_over) begin
          res.peak    = pk_dec;
          res.decayed = 1'b1;
        end
      end
      res.changed = (lv != level) || (res.peak != peak);
    end
  end

endmodule

// File: hw/rtl/peak_hold_level_meter_top.sv
// ----------------------------------------------------------------------------
// peak_hold_level_meter_top
// Peak-hold level meter: smoothed levels, held peaks and a latched clip class.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  in_      | slave     | one refresh beat: gains, channel count, time
//  out_     | master    | one result beat per refresh: levels, peaks, flags
//  cfg_     | write     | hold time, hold enable, clip and warn thresholds
//
//  One refresh per cycle sustained while out_tready is high; a beat passes
//  through the input register, then the result register, to out_tvalid.
//  The meter state is updated in the same cycle the result register loads.
//  When out_tready is low and a result is waiting, the input register holds
//  its beat and in_tready drops only once both stages are full.
//  rst_n clears all meter state and valid flags and resets the config registers.
// ----------------------------------------------------------------------------
module peak_hold_level_meter_top
  import phlm_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // gain_in_0, gain_in_1, valid_channels, now_ms (from bit 0), zero padded
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // level_0, level_1, peak_0, peak_1, changed, clip_state (from bit 0), zero padded
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [HOLD_W-1:0] hold_time_r;
  logic              hold_en_r;
  logic [GAIN_W-1:0] clip_thr_r;
  logic [GAIN_W-1:0] warn_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r <= HOLD_TIME_RST;
      hold_en_r   <= 1'b0;
      clip_thr_r  <= CLIP_THR_RST;
      warn_thr_r  <= WARN_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HOLD_TIME: hold_time_r <= cfg_wdata;
        REG_HOLD_EN:   hold_en_r   <= cfg_wdata[0];
        REG_CLIP_THR:  clip_thr_r  <= cfg_wdata;
        REG_WARN_THR:  warn_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic                in_vld_r;
  logic [GAIN_W-1:0]   in_gain_r [2];
  logic [NCH_W-1:0]    in_nch_r;
  logic [TIME_W-1:0]   in_now_r;
  logic                advance;

  assign advance   = in_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_gain_r[0] <= in_tdata[0 +: GAIN_W];
      in_gain_r[1] <= in_tdata[GAIN_W +: GAIN_W];
      in_nch_r     <= in_tdata[2*GAIN_W +: NCH_W];
      in_now_r     <= in_tdata[2*GAIN_W+NCH_W +: TIME_W];
    end
  end

  // meter state
  logic [GAIN_W-1:0] level_r [CHANNELS];
  logic [GAIN_W-1:0] peak_r  [CHANNELS];
  logic [TIME_W-1:0] stamp_r [CHANNELS];
  logic [CLS_W-1:0]  cls_r;
  logic [CLS_W-1:0]  cls_nxt;
  chan_res_t         res [CHANNELS];

  // per-channel update
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    phlm_chan u_chan (
      .gain      (in_gain_r[ch]),
      .level     (level_r[ch]),
      .peak      (peak_r[ch]),
      .stamp     (stamp_r[ch]),
      .now       (in_now_r),
      .hold_en   (hold_en_r),
      .hold_time (hold_time_r),
      .upd       (in_nch_r > NCH_W'(ch)),
      .res       (res[ch])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        level_r[ch] <= '0;
        peak_r[ch]  <= '0;
        stamp_r[ch] <= '0;
      end else if (advance) begin
        level_r[ch] <= res[ch].level;
        peak_r[ch]  <= res[ch].peak;
        stamp_r[ch] <= res[ch].stamp;
      end
    end
  end

  // largest level, class and latching
  logic              any_chg;
  logic              any_dec;
  logic [GAIN_W-1:0] max_lv;
  logic [CLS_W-1:0]  cls_new;

  always_comb begin
    any_chg = 1'b0;
    any_dec = 1'b0;
    max_lv  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      any_chg = any_chg | res[i].changed;
      any_dec = any_dec | res[i].decayed;
      if (res[i].level > max_lv) max_lv = res[i].level;
    end
    priority if (max_lv >= clip_thr_r) cls_new = CLS_CLIP;
    else if (max_lv >= warn_thr_r)     cls_new = CLS_WARN;
    else                                cls_new = CLS_NONE;
    cls_nxt = cls_r;
    if (any_chg && ((cls_r < cls_new) || any_dec)) cls_nxt = cls_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= CLS_NONE;
    end else if (advance) begin
      cls_r <= cls_nxt;
    end
  end

  // result register
  logic                  out_vld_r;
  logic [OUT_RAW_W-1:0]  out_data_r;
  logic [OUT_RAW_W-1:0]  out_data_nxt;
  logic [GAIN_W-1:0]     lv_hi;
  logic [GAIN_W-1:0]     pk_hi;

  if (CHANNELS > 1) begin : g_hi
    assign lv_hi = res[CHANNELS-1].level;
    assign pk_hi = res[CHANNELS-1].peak;
  end else begin : g_no_hi
    assign lv_hi = '0;
    assign pk_hi = '0;
  end

  assign out_data_nxt = {cls_nxt, any_chg, pk_hi, res[0].peak, lv_hi, res[0].level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule
